// ===== src/dpu_pkg.sv =====
// Shared types and constants for the depth-to-point unprojection block.
package dpu_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CSTR   = 3'd2;
    localparam logic [2:0] REG_RSTR   = 3'd3;
    localparam logic [2:0] REG_NEAR   = 3'd4;
    localparam logic [2:0] REG_FAR    = 3'd5;
    localparam logic [2:0] REG_IFX    = 3'd6;
    localparam logic [2:0] REG_IFY    = 3'd7;

    localparam logic [24:0] ONE_Q24 = 25'h1000000;

    // Work item handed from the front part to the back part
    typedef struct packed {
        logic [23:0] depth;
        logic [18:0] off_x;   // signed 2c - W
        logic [18:0] off_y;   // signed 2r - H
    } t_job;

endpackage

// ===== src/dpu_front.sv =====
// Front part: raster counters, stride phases and grid/background classification.
module dpu_front import dpu_pkg::*; #(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_STRIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_q,
    input  logic [24:0] i_depth_code,
    input  logic [12:0] i_image_width,
    input  logic [12:0] i_image_height,
    input  logic [6:0]  i_column_stride,
    input  logic [6:0]  i_row_stride,
    output logic        o_stall,
    output logic        o_push,
    output t_job        o_job
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int SW = $clog2(MAX_STRIDE + 1);

    logic [DW-1:0] r_col, r_row, n_col, n_row, w, h;
    logic [SW-1:0] r_cph, r_rph, n_cph, n_rph, cs, rs;
    logic          acc, keep;

    // clamp sizes and strides into their legal ranges
    always_comb begin
        w  = (i_image_width == '0) ? DW'(1) :
             ({19'b0, i_image_width} > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(i_image_width);
        h  = (i_image_height == '0) ? DW'(1) :
             ({19'b0, i_image_height} > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(i_image_height);
        cs = (i_column_stride == '0) ? SW'(1) :
             ({25'b0, i_column_stride} > 32'(MAX_STRIDE)) ? SW'(MAX_STRIDE) :
             SW'(i_column_stride);
        rs = (i_row_stride == '0) ? SW'(1) :
             ({25'b0, i_row_stride} > 32'(MAX_STRIDE)) ? SW'(MAX_STRIDE) :
             SW'(i_row_stride);
    end

    assign o_stall = i_stall_q;
    assign acc     = i_valid && !i_stall_q;
    assign keep    = (r_cph == '0) && (r_rph == '0) && (i_depth_code < ONE_Q24);
    assign o_push  = acc && keep;
    assign o_job.depth = i_depth_code[23:0];
    assign o_job.off_x = 19'({1'b0, r_col, 1'b0}) - 19'(w);
    assign o_job.off_y = 19'({1'b0, r_row, 1'b0}) - 19'(h);

    // raster advance
    always_comb begin
        n_col = r_col; n_row = r_row; n_cph = r_cph; n_rph = r_rph;
        if ({1'b0, r_col} + 1'b1 >= {1'b0, w}) begin
            n_col = '0;
            n_cph = '0;
            if ({1'b0, r_row} + 1'b1 >= {1'b0, h}) begin
                n_row = '0;
                n_rph = '0;
            end else begin
                n_row = r_row + 1'b1;
                n_rph = ({1'b0, r_rph} + 1'b1 >= {1'b0, rs}) ? '0 : r_rph + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
            n_cph = ({1'b0, r_cph} + 1'b1 >= {1'b0, cs}) ? '0 : r_cph + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_cph <= '0; r_rph <= '0;
        end else if (acc) begin
            r_col <= n_col; r_row <= n_row; r_cph <= n_cph; r_rph <= n_rph;
        end
    end
endmodule

// ===== src/dpu_queue.sv =====
// Small two-entry queue between front and back parts.
module dpu_queue import dpu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== src/dpu_div.sv =====
// Radix-2 restoring divider: 88-bit numerator by 58-bit denominator, 64-bit capped quotient.
module dpu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_nf,
    input  logic [57:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [58:0] r_rem;
    logic [63:0] r_q, r_lo;
    logic [57:0] r_den;
    logic [59:0] sh;
    logic [58:0] dif;

    assign sh  = {r_rem, r_lo[63]};
    assign dif = 59'(sh) - {1'b0, r_den};
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else if (i_start) begin
            // numerator is nf * 2^24; high word nf >> 40
            r_rem <= {35'b0, i_nf[63:40]};
            r_lo  <= {i_nf[39:0], 24'b0};
            r_den <= i_den;
            r_q   <= '0;
            if (i_den == '0) begin
                o_done <= 1'b1;      // zero divisor yields zero
            end else if ({35'b0, i_nf[63:40]} >= {1'b0, i_den}) begin
                r_q <= '1;
                o_done <= 1'b1;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end
        end else if (r_busy) begin
            if (sh >= {2'b0, r_den}) begin
                r_rem <= dif;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= sh[58:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
            r_lo  <= {r_lo[62:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
endmodule

// ===== src/dpu_back.sv =====
// Back part: depth linearization, unprojection and saturation sequencer.
module dpu_back import dpu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [31:0] i_near,
    input  logic [31:0] i_far,
    input  logic [31:0] i_ifx,
    input  logic [31:0] i_ify,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_x,
    output logic [31:0] o_y,
    output logic [31:0] o_z
);
    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_DEN, S_DIV, S_AX, S_PX, S_AY, S_PY, S_OUT
    } t_state;

    t_state      r_st;
    t_job        r_job;
    logic [63:0] r_p, r_q;
    logic [57:0] r_den;
    logic [57:0] den_sum;
    logic [63:0] r_z;
    logic [49:0] r_a;      // |off| * inv
    logic [81:0] r_acc;
    logic [2:0]  r_part;
    logic        r_neg;
    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [17:0] mag;
    logic        offneg;
    logic [18:0] off;
    logic [31:0] inv;
    logic [31:0] apart;
    logic [31:0] zpart;
    logic [63:0] pp;
    logic [81:0] addend;
    logic        addovf;
    logic [82:0] addsum;
    logic [48:0] val;
    logic [31:0] sat;

    assign o_pop     = (r_st == S_IDLE) && i_valid;
    assign div_start = (r_st == S_DEN);
    // full divisor F*(1-d) + N*d, taken by the divider as it starts
    assign den_sum   = r_den + 58'(r_q);

    dpu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_nf(r_p), .i_den(den_sum), .o_done(div_done), .o_quo(div_q)
    );

    // axis operand select
    assign off    = (r_st == S_AX || r_st == S_PX) ? r_job.off_x : r_job.off_y;
    assign inv    = (r_st == S_AX || r_st == S_PX) ? i_ifx : i_ify;
    assign offneg = off[18];
    assign mag    = offneg ? 18'(-off) : off[17:0];
    // a and z split in 32-bit halves, one partial product a cycle
    assign apart  = r_part[1] ? 32'(r_a[49:32]) : r_a[31:0];
    assign zpart  = r_part[0] ? r_z[63:32] : r_z[31:0];
    assign pp     = 64'(apart) * 64'(zpart);

    // align the partial product; anything reaching past bit 81 saturates
    always_comb begin
        case (r_part)
            3'd1, 3'd2: begin
                addend = {pp[49:0], 32'b0};
                addovf = pp[63:50] != '0;
            end
            3'd3: begin
                addend = {pp[17:0], 64'b0};
                addovf = pp[63:18] != '0;
            end
            default: begin
                addend = 82'(pp);
                addovf = 1'b0;
            end
        endcase
    end

    assign addsum = {1'b0, r_acc} + {1'b0, addend};
    assign val    = (r_acc[81:33] != '0 && r_acc[81:64] != '0) ? '1 : r_acc[81:33];

    // saturate magnitude with sign
    function automatic logic [31:0] f_sat(input logic [63:0] m, input logic neg);
        if (neg) return (m >= 64'h80000000) ? 32'h80000000 : 32'(-m[31:0]);
        return (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    endfunction

    assign sat = f_sat({15'b0, val}, r_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_st  <= S_M1;
                end
                S_M1: begin
                    // N*F and F*(1-d)
                    r_p <= 64'(i_near) * 64'(i_far);
                    r_q <= 64'(i_far) * 64'(25'(ONE_Q24 - {1'b0, r_job.depth}));
                    r_st <= S_M2;
                end
                S_M2: begin
                    r_den <= 58'(r_q);
                    r_q   <= 64'(i_near) * 64'(r_job.depth);
                    r_st  <= S_DEN;
                end
                S_DEN: begin
                    r_den <= den_sum;
                    r_st  <= S_DIV;
                end
                S_DIV: if (div_done) begin
                    r_z  <= div_q;
                    r_st <= S_AX;
                end
                S_AX, S_AY: begin
                    r_a    <= 50'(mag) * 50'(inv);
                    r_neg  <= (r_st == S_AY) ? !offneg : offneg;
                    r_acc  <= '0;
                    r_part <= 3'd0;
                    r_st   <= (r_st == S_AX) ? S_PX : S_PY;
                end
                S_PX, S_PY: begin
                    if (r_part != 3'd4) begin
                        r_acc  <= (addovf || addsum[82]) ? '1 : addsum[81:0];
                        r_part <= r_part + 3'd1;
                    end else begin
                        if (r_st == S_PX) begin
                            o_x  <= sat;
                            r_st <= S_AY;
                        end else begin
                            o_y     <= sat;
                            o_z     <= f_sat(r_z, 1'b1);
                            o_valid <= 1'b1;
                            r_st    <= S_OUT;
                        end
                    end
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/depth_to_point_unprojection.sv =====
// Top level of the depth-to-point unprojection block.
//  channel | direction | handshake
//  depth   | in        | i_valid / o_stall
//  point   | out       | o_valid / i_stall
//  config  | in        | i_cfg_we, i_cfg_index, i_cfg_data
// Off-grid and background pixels take one cycle each in the front part.
// A kept pixel holds the back part through the divider until its point is taken.
// A two-entry queue lets the front keep taking pixels while the back works;
// the input stalls only while that queue is full.
// Reset is synchronous; it restores register defaults and clears counters.
module depth_to_point_unprojection import dpu_pkg::*; #(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_STRIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [24:0] i_depth_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [31:0] o_point_z,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [12:0] r_w, r_h;
    logic [6:0]  r_cs, r_rs;
    logic [31:0] r_near, r_far, r_ifx, r_ify;
    logic        push, qfull, qvalid, pop;
    t_job        fjob, bjob;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 13'd1200; r_h <= 13'd900; r_cs <= 7'd10; r_rs <= 7'd10;
            r_near <= 32'd655; r_far <= 32'd3276800;
            r_ifx <= 32'd2966000; r_ify <= 32'd2966000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_w    <= i_cfg_data[12:0];
                REG_HEIGHT: r_h    <= i_cfg_data[12:0];
                REG_CSTR:   r_cs   <= i_cfg_data[6:0];
                REG_RSTR:   r_rs   <= i_cfg_data[6:0];
                REG_NEAR:   r_near <= i_cfg_data;
                REG_FAR:    r_far  <= i_cfg_data;
                REG_IFX:    r_ifx  <= i_cfg_data;
                REG_IFY:    r_ify  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpu_front #(.MAX_DIM(MAX_DIM), .MAX_STRIDE(MAX_STRIDE)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_q(qfull),
        .i_depth_code(i_depth_code), .i_image_width(r_w), .i_image_height(r_h),
        .i_column_stride(r_cs), .i_row_stride(r_rs),
        .o_stall(o_stall), .o_push(push), .o_job(fjob)
    );

    dpu_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob),
        .o_full(qfull), .o_valid(qvalid), .i_pop(pop), .o_job(bjob)
    );

    dpu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qvalid), .i_job(bjob), .o_pop(pop),
        .i_near(r_near), .i_far(r_far), .i_ifx(r_ifx), .i_ify(r_ify),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_x(o_point_x), .o_y(o_point_y), .o_z(o_point_z)
    );
endmodule

// ===== src/dpu_checker.sv =====
// Port-level checker for the unprojection block, bound to the top level.
module dpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [24:0] i_depth_code,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_point_x,
    input logic [31:0] o_point_y,
    input logic [31:0] o_point_z
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_x) && $stable(o_point_y) &&
        $stable(o_point_z)) else $error("result changed");
    // pixel held while stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_depth_code))
        else $error("pixel changed while stalled");
    // depth is never positive in camera frame
    a_zneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_point_z[31] || o_point_z == 32'd0) else $error("z positive");
    // a result goes away after its transfer
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid) else $error("result repeated");
    // no output right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind depth_to_point_unprojection dpu_checker u_chk (.*);

// ===== tb/tb_depth_to_point_unprojection.sv =====
// Self-checking testbench for the depth-to-point unprojection block.
module tb_depth_to_point_unprojection;
    import dpu_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [24:0] i_depth_code;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_point_x;
    logic [31:0] o_point_y;
    logic [31:0] o_point_z;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    depth_to_point_unprojection u_dut (.*);

    // Predictor copy of the registers and raster position
    logic [12:0] cam_width, cam_height;
    logic [6:0]  cam_cstride, cam_rstride;
    logic [31:0] cam_near, cam_far, cam_ifx, cam_ify;
    int unsigned pix_col, pix_row, col_phase, row_phase;

    logic [24:0] pixel_q[$];
    t_point      point_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_left;
    int mismatches;
    int points_seen;
    int pixels_sent;
    int quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Signed saturation of a magnitude to 32 bits
    function automatic logic [31:0] sat32(logic [127:0] mag, bit neg);
        if (neg) begin
            if (mag >= 128'h8000_0000) return 32'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [31:0] axis_point(int off2, logic [127:0] z,
                                               logic [31:0] inv, bit negate);
        logic [127:0] prod;
        bit           neg;
        neg  = (off2 < 0) != negate;
        prod = 128'(off2 < 0 ? -off2 : off2) * 128'(inv) * z;
        return sat32(prod >> 33, neg);
    endfunction

    // Queue one pixel for the driver
    function automatic void add_pixel(logic [24:0] d);
        pixel_q = {pixel_q, d};
    endfunction

    // Expected point for one accepted pixel, then raster advance
    function automatic void unproject_pixel(logic [24:0] depth);
        int unsigned  w, h, cs, rs;
        logic [127:0] num, den, z;
        t_point       p;
        w  = clamp_to(cam_width, 4096);
        h  = clamp_to(cam_height, 4096);
        cs = clamp_to(cam_cstride, 64);
        rs = clamp_to(cam_rstride, 64);
        if (col_phase == 0 && row_phase == 0 && depth < ONE_Q24) begin
            num = (128'(cam_near) * 128'(cam_far)) << 24;
            den = 128'(cam_far) * 128'(ONE_Q24 - depth) + 128'(cam_near) * 128'(depth);
            z = 0;
            if (den != 0) z = num / den;
            if (z > 128'hFFFF_FFFF_FFFF_FFFF) z = 128'hFFFF_FFFF_FFFF_FFFF;
            p.x = axis_point(2 * int'(pix_col) - int'(w), z, cam_ifx, 1'b0);
            p.y = axis_point(2 * int'(pix_row) - int'(h), z, cam_ify, 1'b1);
            p.z = sat32(z, 1'b1);
            point_q = {point_q, p};
        end
        if (pix_col + 1 >= w) begin
            pix_col   = 0;
            col_phase = 0;
            if (pix_row + 1 >= h) begin
                pix_row   = 0;
                row_phase = 0;
            end else begin
                pix_row   = pix_row + 1;
                row_phase = (row_phase + 1 >= rs) ? 0 : row_phase + 1;
            end
        end else begin
            pix_col   = pix_col + 1;
            col_phase = (col_phase + 1 >= cs) ? 0 : col_phase + 1;
        end
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_WIDTH:  cam_width   = val[12:0];
            REG_HEIGHT: cam_height  = val[12:0];
            REG_CSTR:   cam_cstride = val[6:0];
            REG_RSTR:   cam_rstride = val[6:0];
            REG_NEAR:   cam_near    = val;
            REG_FAR:    cam_far     = val;
            REG_IFX:    cam_ifx     = val;
            REG_IFY:    cam_ify     = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_camera(logic [31:0] w, logic [31:0] h, logic [31:0] cs,
                              logic [31:0] rs, logic [31:0] nr, logic [31:0] fr,
                              logic [31:0] ifx, logic [31:0] ify);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_CSTR, cs);
        write_reg(REG_RSTR, rs);
        write_reg(REG_NEAR, nr);
        write_reg(REG_FAR, fr);
        write_reg(REG_IFX, ifx);
        write_reg(REG_IFY, ify);
    endtask

    // Wait for every pixel to go in and every point to come out, then let the
    // back end settle.
    task automatic drain();
        while (pixel_q.size() != 0 || i_valid || point_q.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [24:0] rand_depth();
        case ($urandom_range(9))
            0: return 25'd0;
            1: return ONE_Q24 - 25'd1;
            2, 3: return 25'($urandom_range(32'hFF_FFFF, 32'h100_0000)) | ONE_Q24;
            default: return 25'($urandom_range(32'hFF_FFFF));
        endcase
    endfunction

    function automatic logic [31:0] rand_dist();
        case ($urandom_range(5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            default: return $urandom_range(32'h00FF_FFFF, 1);
        endcase
    endfunction

    // Pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_depth_code <= '0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                unproject_pixel(i_depth_code);
                pixels_sent++;
            end
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid      <= 1'b1;
                i_depth_code <= pixel_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Point receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_req;
            hold_req  <= 0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Point checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_point want;
            points_seen++;
            if (point_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%h y=%h z=%h",
                             o_point_x, o_point_y, o_point_z);
            end else begin
                want = point_q.pop_front();
                if (want.x !== o_point_x || want.y !== o_point_y ||
                    want.z !== o_point_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: want %h %h %h got %h %h %h",
                                 want.x, want.y, want.z,
                                 o_point_x, o_point_y, o_point_z);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("depth_to_point_unprojection regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        mismatches     = 0;
        points_seen    = 0;
        pixels_sent    = 0;
        quiet_cycles   = 0;
        cam_width   = 13'd1200;
        cam_height  = 13'd900;
        cam_cstride = 7'd10;
        cam_rstride = 7'd10;
        cam_near    = 32'd655;
        cam_far     = 32'd3276800;
        cam_ifx     = 32'd2966000;
        cam_ify     = 32'd2966000;
        pix_col = 0;
        pix_row = 0;
        col_phase = 0;
        row_phase = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: depth extremes on and off the grid
        add_pixel(25'd0);
        add_pixel(ONE_Q24 - 25'd1);
        repeat (8) add_pixel(25'd1);
        add_pixel(ONE_Q24 - 25'd1);
        add_pixel(ONE_Q24);
        drain();

        // Tiny frame, out-of-range sizes and strides,
        // zero far plane (zero divisor at depth zero), widest reciprocals
        set_camera(32'd0, 32'd3, 32'd0, 32'd127, 32'd1, 32'd0,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_pixel(25'd0);
        add_pixel(25'd1);
        add_pixel(ONE_Q24 - 25'd1);
        add_pixel(25'h1FF_FFFF);
        drain();

        // Huge near and far with saturating x and a zero y reciprocal, largest frame size
        set_camera(32'd8191, 32'd4096, 32'd64, 32'd1, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        add_pixel(25'd0);
        add_pixel(ONE_Q24 - 25'd1);
        repeat (63) add_pixel(25'd5);
        add_pixel(25'h0AA_AAAA);
        drain();

        // Random phases: mostly small frames and strides, with idling modes
        for (phase = 0; phase < 8; phase++) begin
            int n;
            set_camera($urandom_range(4) == 0 ? 32'($urandom_range(8191)) :
                           32'($urandom_range(12)),
                       32'($urandom_range(10)),
                       $urandom_range(5) == 0 ? 32'($urandom_range(127)) :
                           32'($urandom_range(3)),
                       32'($urandom_range(3)),
                       rand_dist(), rand_dist(), $urandom(), $urandom());
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // Long receiver hold-off while pixels keep coming
            if (phase == 4) hold_req = 600;
            n = 65;
            while (n > 0) begin
                add_pixel(rand_depth());
                n--;
            end
            drain();
        end

        $display("pixels sent: %0d, points checked: %0d, over 11 camera setups",
                 pixels_sent, points_seen);
        $display("covered size/stride clamping, saturation, background and stalls");
        if (mismatches == 0 && point_q.size() == 0)
            $display("depth_to_point_unprojection regression: pass");
        else
            $display("depth_to_point_unprojection regression: fail");
        $finish;
    end

endmodule
